[rtl/core/pptcc_pkg.sv]
// shared types, constants and register indexes for the ping/pong charge capture block
// no dependencies; compiled first
package pptcc_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int LEVEL_BITS      = 16;
    localparam int COUNT_BITS      = 10;
    localparam int GAIN_BITS       = 16;
    localparam int OFFSET_BITS     = 16;
    localparam int CHARGE_BITS     = 14;
    localparam int CHARGE_MAX      = 10240;
    localparam int CFG_IDX_BITS    = 3;
    localparam int CFG_DATA_BITS   = 16;

    localparam logic [LEVEL_BITS-1:0]  LEVEL_RST  = 16'd90;
    localparam logic [COUNT_BITS-1:0]  HOLD_RST   = 10'd42;
    localparam logic [COUNT_BITS-1:0]  DEAD_RST   = 10'd90;
    localparam logic [GAIN_BITS-1:0]   GAIN_RST   = 16'd19995;
    localparam logic [OFFSET_BITS-1:0] OFFSET_RST = 16'd1213;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_TRIGGER_LEVEL = 3'd0,
        CFG_HOLD_DELAY    = 3'd1,
        CFG_DEAD_SAMPLES  = 3'd2,
        CFG_CHARGE_GAIN   = 3'd3,
        CFG_CHARGE_OFFSET = 3'd4
    } t_cfg_idx;

    // capture tag carried alongside the slow sample
    typedef struct packed {
        logic                  is_pong;
        logic [COUNT_BITS-1:0] position;
    } t_capture;

endpackage

[rtl/core/pptcc_in_if.sv]
// sample input channel: valid/ready plus one fast/slow sample pair
// depends on pptcc_pkg
interface pptcc_in_if #(
    parameter int SAMPLE_BITS = pptcc_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] fast_sample;
    logic signed [SAMPLE_BITS-1:0] slow_sample;
    logic                          event_start;

    modport source (output valid, output fast_sample, output slow_sample,
                    output event_start, input ready);
    modport sink   (input valid, input fast_sample, input slow_sample,
                    input event_start, output ready);
endinterface

[rtl/core/pptcc_out_if.sv]
// capture result channel: valid/ready plus charge, ping/pong flag and trigger position
// depends on pptcc_pkg
interface pptcc_out_if;
    logic                                   valid;
    logic                                   ready;
    logic [pptcc_pkg::CHARGE_BITS-1:0]      charge;
    logic                                   is_pong;
    logic [pptcc_pkg::COUNT_BITS-1:0]       trigger_position;

    modport source (output valid, output charge, output is_pong,
                    output trigger_position, input ready);
    modport sink   (input valid, input charge, input is_pong,
                    input trigger_position, output ready);
endinterface

[rtl/core/pptcc_ctrl.sv]
// trigger/phase sequencer: event window, ping/pong arming, dead and hold counters
// depends on pptcc_pkg and pptcc_in_if; holds the first pipeline register
module pptcc_ctrl #(
    parameter int SAMPLE_BITS = pptcc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    pptcc_in_if.sink                              i_sample,
    input  logic [pptcc_pkg::LEVEL_BITS-1:0]      i_level,
    input  logic [pptcc_pkg::COUNT_BITS-1:0]      i_hold_delay,
    input  logic [pptcc_pkg::COUNT_BITS-1:0]      i_dead_samples,
    input  logic                                  i_take,
    output logic                                  o_valid,
    output logic signed [SAMPLE_BITS-1:0]         o_slow,
    output pptcc_pkg::t_capture                   o_cap
);
    import pptcc_pkg::*;

    localparam int CMP_BITS = (SAMPLE_BITS > LEVEL_BITS) ? SAMPLE_BITS : LEVEL_BITS;
    localparam logic [COUNT_BITS-1:0] LAST_INDEX = {COUNT_BITS{1'b1}};

    typedef enum logic [1:0] {
        PH_PING = 2'd0,
        PH_DEAD = 2'd1,
        PH_PONG = 2'd2,
        PH_DONE = 2'd3
    } t_phase;

    t_phase                  r_phase, n_phase;
    logic [COUNT_BITS-1:0]   r_dead, n_dead;
    logic [COUNT_BITS-1:0]   r_hold, n_hold;
    logic                    r_pend, n_pend;
    logic                    r_ppong, n_ppong;
    logic [COUNT_BITS-1:0]   r_ppos, n_ppos;
    logic [COUNT_BITS-1:0]   r_idx, n_idx;
    logic                    r_valid;
    logic signed [SAMPLE_BITS-1:0] r_slow;
    t_capture                r_cap;

    logic                    w_en;
    logic                    w_accept;
    logic                    w_busy;
    logic                    w_fire;
    logic                    w_emit;
    logic [COUNT_BITS-1:0]   w_pos;
    t_capture                w_cap;
    logic signed [CMP_BITS-1:0] w_fast_x;
    logic signed [CMP_BITS-1:0] w_level_x;

    assign w_en       = !r_valid || i_take;
    assign i_sample.ready = w_en;
    assign w_accept   = i_sample.valid && w_en;
    assign w_fast_x   = CMP_BITS'(i_sample.fast_sample);
    assign w_level_x  = CMP_BITS'($signed(i_level));

    always_comb begin
        n_phase = r_phase;
        n_dead  = r_dead;
        n_hold  = r_hold;
        n_pend  = r_pend;
        n_ppong = r_ppong;
        n_ppos  = r_ppos;
        n_idx   = r_idx;
        w_emit  = 1'b0;
        w_cap   = '{is_pong: r_ppong, position: r_ppos};
        w_fire  = 1'b0;
        w_pos   = r_idx;
        w_busy  = 1'b0;

        // new event: clear phase and window
        if (i_sample.event_start) begin
            n_phase = PH_PING;
            n_dead  = '0;
            n_hold  = '0;
            n_pend  = 1'b0;
            n_idx   = '0;
        end
        w_pos  = n_idx;
        w_busy = n_pend;

        // pending capture counts down to its slow sample
        if (w_busy) begin
            n_hold = n_hold - 1'b1;
            if (n_hold == '0) begin
                w_emit = 1'b1;
                w_cap  = '{is_pong: r_ppong, position: r_ppos};
                n_pend = 1'b0;
            end
        end

        if (n_phase == PH_DEAD) begin
            n_dead = n_dead - 1'b1;
            if (n_dead == '0) begin
                n_phase = PH_PONG;
            end
        end

        w_fire = (n_phase == PH_PING || n_phase == PH_PONG) && (w_fast_x >= w_level_x)
                 && !w_busy;
        if (w_fire) begin
            if (n_phase == PH_PONG) begin
                n_phase = PH_DONE;
                n_ppong = 1'b1;
            end else begin
                n_phase = PH_DEAD;
                n_dead  = (i_dead_samples == '0) ? COUNT_BITS'(1) : i_dead_samples;
                n_ppong = 1'b0;
            end
            if (i_hold_delay == '0) begin
                // zero delay: capture the trigger sample itself
                w_emit = 1'b1;
                w_cap  = '{is_pong: n_ppong, position: w_pos};
                n_ppong = r_ppong;
            end else begin
                n_pend = 1'b1;
                n_hold = i_hold_delay;
                n_ppos = w_pos;
            end
        end

        // window end closes the event
        if (w_pos == LAST_INDEX) begin
            n_phase = PH_DONE;
            n_pend  = 1'b0;
        end else begin
            n_idx = w_pos + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PING;
            r_dead  <= '0;
            r_hold  <= '0;
            r_pend  <= 1'b0;
            r_ppong <= 1'b0;
            r_ppos  <= '0;
            r_idx   <= '0;
            r_valid <= 1'b0;
            r_slow  <= '0;
            r_cap   <= '0;
        end else begin
            if (w_accept) begin
                r_phase <= n_phase;
                r_dead  <= n_dead;
                r_hold  <= n_hold;
                r_pend  <= n_pend;
                r_ppong <= n_ppong;
                r_ppos  <= n_ppos;
                r_idx   <= n_idx;
            end
            if (w_en) begin
                r_valid <= w_accept && w_emit;
                r_slow  <= i_sample.slow_sample;
                r_cap   <= w_cap;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_slow  = r_slow;
    assign o_cap   = r_cap;

endmodule

[rtl/core/pptcc_scale.sv]
// charge scaling pipeline: gain multiply, pedestal add, rounding, saturation, result register
// depends on pptcc_pkg and pptcc_out_if
module pptcc_scale #(
    parameter int SAMPLE_BITS = pptcc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  logic signed [SAMPLE_BITS-1:0]         i_slow,
    input  pptcc_pkg::t_capture                   i_cap,
    input  logic [pptcc_pkg::GAIN_BITS-1:0]       i_gain,
    input  logic [pptcc_pkg::OFFSET_BITS-1:0]     i_offset,
    output logic                                  o_take,
    pptcc_out_if.source                           o_capture
);
    import pptcc_pkg::*;

    localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS + 1;
    localparam int BIAS_BITS = OFFSET_BITS + 14;
    localparam int ACC_BITS  = ((PROD_BITS > BIAS_BITS) ? PROD_BITS : BIAS_BITS) + 1;
    localparam int Q_BITS    = ACC_BITS - 16;

    logic                        r_v2;
    logic signed [PROD_BITS-1:0] r_prod;
    t_capture                    r_cap2;
    logic                        r_v3;
    logic [CHARGE_BITS-1:0]      r_charge;
    t_capture                    r_cap3;

    logic                        w_en2;
    logic                        w_en3;
    logic signed [PROD_BITS-1:0] w_prod;
    logic [BIAS_BITS-1:0]        w_bias;
    logic signed [ACC_BITS-1:0]  w_acc;
    logic [Q_BITS-1:0]           w_q;
    logic [CHARGE_BITS-1:0]      w_charge;

    assign w_en3  = !r_v3 || o_capture.ready;
    assign w_en2  = !r_v2 || w_en3;
    assign o_take = w_en2;

    assign w_prod = PROD_BITS'(i_slow) * PROD_BITS'($signed({1'b0, i_gain}));

    // pedestal in 1/16 units scaled to Q16, plus half for round-half-up
    // two spare top bits keep the sum positive even at the largest pedestal
    assign w_bias = {2'b00, i_offset, 12'd0} + BIAS_BITS'(32768);
    assign w_acc  = ACC_BITS'(r_prod) + ACC_BITS'($signed(w_bias));
    assign w_q    = w_acc[ACC_BITS-1:16];

    always_comb begin
        if (w_acc[ACC_BITS-1]) begin
            w_charge = '0;
        end else if (w_q > Q_BITS'(CHARGE_MAX)) begin
            w_charge = CHARGE_BITS'(CHARGE_MAX);
        end else begin
            w_charge = w_q[CHARGE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en2) begin
                r_v2 <= i_valid;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_prod <= w_prod;
            r_cap2 <= i_cap;
        end
        if (w_en3) begin
            r_charge <= w_charge;
            r_cap3   <= r_cap2;
        end
    end

    assign o_capture.valid            = r_v3;
    assign o_capture.charge           = r_charge;
    assign o_capture.is_pong          = r_cap3.is_pong;
    assign o_capture.trigger_position = r_cap3.position;

endmodule

[rtl/core/ping_pong_trigger_charge_capture.sv]
// top level of the ping/pong discriminator-triggered charge capture block
// depends on pptcc_pkg, pptcc_in_if, pptcc_out_if, pptcc_ctrl and pptcc_scale
//
// one fast/slow shaper sample pair is taken per transfer, one per clock when the
// result side keeps up. the first fast sample at or above trigger_level in an
// event starts a ping capture; the slow sample hold_delay samples later is scaled
// by the Q0.16 gain, the 1/16-unit pedestal is added, rounded half up and
// saturated to 0..10240. from dead_samples after the ping trigger a second
// trigger gives the pong capture; later triggers are ignored, and an event
// closes after 1024 samples, dropping any capture still due. a capture reaches
// the result channel through the sequencer, multiplier and result registers
// after the transfer of the sample that completes it. each register stage only
// stalls when the stage after it is full, so bubbles are squeezed out and
// samples keep flowing while a result waits. configuration is written through
// the plain write port, only while idle: a user rule the block does not enforce
module ping_pong_trigger_charge_capture #(
    parameter int SAMPLE_BITS = pptcc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [pptcc_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [pptcc_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    pptcc_in_if.sink                               i_sample,
    pptcc_out_if.source                            o_capture
);
    import pptcc_pkg::*;

    // configuration registers
    logic [LEVEL_BITS-1:0]  r_level;
    logic [COUNT_BITS-1:0]  r_hold_delay;
    logic [COUNT_BITS-1:0]  r_dead_samples;
    logic [GAIN_BITS-1:0]   r_gain;
    logic [OFFSET_BITS-1:0] r_offset;

    // sequencer to scaler hand-off
    logic                          w_v1;
    logic signed [SAMPLE_BITS-1:0] w_slow;
    t_capture                      w_cap;
    logic                          w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level        <= LEVEL_RST;
            r_hold_delay   <= HOLD_RST;
            r_dead_samples <= DEAD_RST;
            r_gain         <= GAIN_RST;
            r_offset       <= OFFSET_RST;
        end else if (i_cfg_we) begin
            // writes beyond the register list are ignored
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TRIGGER_LEVEL: r_level        <= i_cfg_data[LEVEL_BITS-1:0];
                CFG_HOLD_DELAY:    r_hold_delay   <= i_cfg_data[COUNT_BITS-1:0];
                CFG_DEAD_SAMPLES:  r_dead_samples <= i_cfg_data[COUNT_BITS-1:0];
                CFG_CHARGE_GAIN:   r_gain         <= i_cfg_data[GAIN_BITS-1:0];
                CFG_CHARGE_OFFSET: r_offset       <= i_cfg_data[OFFSET_BITS-1:0];
                default: ;
            endcase
        end
    end

    // trigger sequencing and capture selection, first register stage
    pptcc_ctrl #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample       (i_sample),
        .i_level        (r_level),
        .i_hold_delay   (r_hold_delay),
        .i_dead_samples (r_dead_samples),
        .i_take         (w_take),
        .o_valid        (w_v1),
        .o_slow         (w_slow),
        .o_cap          (w_cap)
    );

    // gain/pedestal scaling and result register
    pptcc_scale #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_v1),
        .i_slow    (w_slow),
        .i_cap     (w_cap),
        .i_gain    (r_gain),
        .i_offset  (r_offset),
        .o_take    (w_take),
        .o_capture (o_capture)
    );

endmodule

[dv/ping_pong_trigger_charge_capture_tb.sv]
// self-checking testbench for ping_pong_trigger_charge_capture: directed and random
// sample streams, every capture compared against an in-bench predictor of the block
// depends on pptcc_pkg, pptcc_in_if, pptcc_out_if and the block under test
module ping_pong_trigger_charge_capture_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pptcc_pkg::*;

    localparam int SB           = SAMPLE_BITS_DEF;
    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 10;
    // the result passes the pipeline registers after the transfer; allow some slack
    localparam int PIPE_SETTLE  = 8;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 120;
    localparam int PHASE_ITEMS  = 20;
    localparam int LAST_INDEX   = 1023;
    localparam int HOLD_OFF_LEN = 400;

    typedef enum logic [1:0] {
        ARM_PING,
        DEAD_TIME,
        ARM_PONG,
        EVENT_DONE
    } t_capture_phase;

    typedef struct {
        logic [CHARGE_BITS-1:0] charge;
        logic                   is_pong;
        logic [COUNT_BITS-1:0]  position;
    } t_expected;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    pptcc_in_if #(.SAMPLE_BITS(SB)) sample_if ();
    pptcc_out_if                    capture_if ();

    ping_pong_trigger_charge_capture #(
        .SAMPLE_BITS(SB)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sample   (sample_if),
        .o_capture  (capture_if)
    );

    // ------------------------------------------------------------------
    // predictor: register copies, event state and the store of captures
    // still owed by the block
    // ------------------------------------------------------------------
    logic signed [LEVEL_BITS-1:0] level_reg  = LEVEL_RST;
    logic [COUNT_BITS-1:0]        hold_reg   = HOLD_RST;
    logic [COUNT_BITS-1:0]        dead_reg   = DEAD_RST;
    logic [GAIN_BITS-1:0]         gain_reg   = GAIN_RST;
    logic [OFFSET_BITS-1:0]       offset_reg = OFFSET_RST;

    t_capture_phase        phase_q        = ARM_PING;
    logic [COUNT_BITS-1:0] dead_countdown = '0;
    logic [COUNT_BITS-1:0] hold_countdown = '0;
    logic                  pending_q      = 1'b0;
    logic                  pending_pong_q = 1'b0;
    logic [COUNT_BITS-1:0] pending_pos_q  = '0;
    logic [COUNT_BITS-1:0] index_q        = '0;

    t_expected expected_captures[$];

    int error_count      = 0;
    int cycle_count      = 0;
    int send_idle_pct    = 28;
    int recv_idle_pct    = 59;
    int hold_off_request = 0;
    int hold_off_left    = 0;

    // slow sample times Q0.16 gain plus pedestal (1/16 units), ties rounded up,
    // clipped to 0..CHARGE_MAX
    function automatic logic [CHARGE_BITS-1:0] scale_to_charge(logic signed [SB-1:0] slow);
        longint acc;
        acc = longint'(slow) * longint'(gain_reg) + longint'(offset_reg) * 4096 + 32768;
        if (acc < 0) begin
            return '0;
        end
        acc = acc >>> 16;
        if (acc > CHARGE_MAX) begin
            acc = CHARGE_MAX;
        end
        return acc[CHARGE_BITS-1:0];
    endfunction

    // advance the event state by one accepted sample and queue any capture it completes
    function automatic void predict_capture(logic signed [SB-1:0] fast,
                                            logic signed [SB-1:0] slow, logic ev);
        logic [COUNT_BITS-1:0] idx;
        logic                  busy;
        logic                  pong;
        if (ev) begin
            // new event: rearm ping, drop anything still held
            phase_q        = ARM_PING;
            dead_countdown = '0;
            hold_countdown = '0;
            pending_q      = 1'b0;
            index_q        = '0;
        end
        idx  = index_q;
        busy = pending_q;

        if (pending_q) begin
            hold_countdown = hold_countdown - 1'b1;
            if (hold_countdown == '0) begin
                expected_captures.push_back('{charge: scale_to_charge(slow),
                                              is_pong: pending_pong_q,
                                              position: pending_pos_q});
                pending_q = 1'b0;
            end
        end

        if (phase_q == DEAD_TIME) begin
            dead_countdown = dead_countdown - 1'b1;
            if (dead_countdown == '0) begin
                phase_q = ARM_PONG;
            end
        end

        // a trigger on a sample that began with a capture held is ignored
        if ((phase_q == ARM_PING || phase_q == ARM_PONG) && fast >= level_reg && !busy) begin
            pong = (phase_q == ARM_PONG);
            if (pong) begin
                phase_q = EVENT_DONE;
            end else begin
                phase_q        = DEAD_TIME;
                dead_countdown = (dead_reg == '0) ? COUNT_BITS'(1) : dead_reg;
            end
            if (hold_reg == '0) begin
                expected_captures.push_back('{charge: scale_to_charge(slow),
                                              is_pong: pong, position: idx});
            end else begin
                pending_q      = 1'b1;
                hold_countdown = hold_reg;
                pending_pong_q = pong;
                pending_pos_q  = idx;
            end
        end

        // window closes after the last index; a held capture is lost
        if (idx >= LAST_INDEX) begin
            phase_q   = EVENT_DONE;
            pending_q = 1'b0;
        end else begin
            index_q = idx + 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------
    // clock, cycle limit
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // receiver: random stalls, plus a long hold-off when one is requested
    // ------------------------------------------------------------------
    initial begin
        capture_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_left > 0) begin
                capture_if.ready = 1'b0;
                hold_off_left--;
            end else if (hold_off_request > 0) begin
                hold_off_left    = hold_off_request - 1;
                hold_off_request = 0;
                capture_if.ready = 1'b0;
            end else begin
                capture_if.ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // result check: each capture transfer against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : capture_check
        t_expected want;
        if (i_rst_n && capture_if.valid === 1'b1 && capture_if.ready) begin
            if (expected_captures.size() == 0) begin
                $error("unexpected capture: charge %0d is_pong %0d trigger_position %0d",
                       capture_if.charge, capture_if.is_pong, capture_if.trigger_position);
                error_count++;
            end else begin
                want = expected_captures.pop_front();
                if (capture_if.charge !== want.charge) begin
                    $error("charge: expected %0d, got %0d", want.charge, capture_if.charge);
                    error_count++;
                end
                if (capture_if.is_pong !== want.is_pong) begin
                    $error("is_pong: expected %0d, got %0d", want.is_pong, capture_if.is_pong);
                    error_count++;
                end
                if (capture_if.trigger_position !== want.position) begin
                    $error("trigger_position: expected %0d, got %0d",
                           want.position, capture_if.trigger_position);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic int rand_between(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic logic signed [SB-1:0] rand_sample();
        return SB'($urandom);
    endfunction

    // fast sample on either side of the current trigger level
    function automatic logic signed [SB-1:0] pick_fast(bit above);
        if (above) begin
            return SB'(rand_between(int'(level_reg), 32767));
        end else if (level_reg == -32768) begin
            return rand_sample();
        end
        return SB'(rand_between(-32768, int'(level_reg) - 1));
    endfunction

    // register write through the plain write port, mirrored into the predictor
    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_BITS-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_TRIGGER_LEVEL: level_reg  = data;
            CFG_HOLD_DELAY:    hold_reg   = data[COUNT_BITS-1:0];
            CFG_DEAD_SAMPLES:  dead_reg   = data[COUNT_BITS-1:0];
            CFG_CHARGE_GAIN:   gain_reg   = data;
            CFG_CHARGE_OFFSET: offset_reg = data;
            default: ;
        endcase
    endtask

    task automatic write_all(logic [15:0] level, logic [9:0] hold, logic [9:0] dead,
                             logic [15:0] gain, logic [15:0] offset);
        write_reg(CFG_TRIGGER_LEVEL, level);
        write_reg(CFG_HOLD_DELAY, {6'($urandom), hold});
        write_reg(CFG_DEAD_SAMPLES, {6'($urandom), dead});
        write_reg(CFG_CHARGE_GAIN, gain);
        write_reg(CFG_CHARGE_OFFSET, offset);
    endtask

    // one sample transfer; valid stays high into the next call unless it idles
    task automatic send_sample(logic signed [SB-1:0] fast, logic signed [SB-1:0] slow,
                               logic ev);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            sample_if.valid = 1'b0;
            @(negedge i_clk);
        end
        sample_if.valid       = 1'b1;
        sample_if.fast_sample = fast;
        sample_if.slow_sample = slow;
        sample_if.event_start = ev;
        do @(posedge i_clk); while (!sample_if.ready);
        predict_capture(fast, slow, ev);
    endtask

    // stop offering, let every owed capture arrive, then let the pipeline settle
    task automatic wait_for_captures();
        int waited;
        @(negedge i_clk);
        sample_if.valid = 1'b0;
        waited = 0;
        while (expected_captures.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_captures.size() != 0) begin
            $error("%0d captures never arrived", expected_captures.size());
            error_count++;
            expected_captures.delete();
        end
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // registers at their reset values: ping at sample 0, slow taken 42 samples later
    task automatic test_reset_values();
        send_sample(16'sd90, rand_sample(), 1'b1);
        for (int k = 1; k < 42; k++) begin
            send_sample(SB'(rand_between(-32768, 89)), rand_sample(), 1'b0);
        end
        send_sample(16'sd0, 16'sd1000, 1'b0);
        send_sample(16'sd0, rand_sample(), 1'b0);
    endtask

    // level, gain and pedestal extremes, zero hold delay, zero dead time, tie rounding
    task automatic test_extremes();
        wait_for_captures();
        write_all(16'h7fff, 10'd0, 10'd0, 16'hffff, 16'hffff);
        send_sample(16'sd32766, rand_sample(), 1'b1);   // just below the level
        send_sample(16'sd32767, 16'sd32767, 1'b0);      // ping, saturates high
        send_sample(16'sd32767, -16'sd32768, 1'b0);     // pong on the next sample, clips to 0
        send_sample(16'sd32767, rand_sample(), 1'b0);   // event done, ignored

        wait_for_captures();
        write_reg(CFG_TRIGGER_LEVEL, 16'h8000);
        write_reg(CFG_CHARGE_GAIN, 16'd0);
        write_reg(CFG_CHARGE_OFFSET, 16'd8);            // half an adc unit, rounds up
        send_sample(-16'sd32768, rand_sample(), 1'b1);
        send_sample(-16'sd32768, rand_sample(), 1'b0);

        wait_for_captures();
        write_reg(CFG_CHARGE_GAIN, 16'h8000);
        write_reg(CFG_CHARGE_OFFSET, 16'd0);
        send_sample(16'sd0, -16'sd1, 1'b1);             // minus a half plus rounding: 0
        send_sample(16'sd0, 16'sd1, 1'b0);              // plus a half: rounds to 1
    endtask

    // pong ignored while a capture is held, event start dropping a held capture
    task automatic test_busy_and_event_start();
        wait_for_captures();
        write_all(16'd100, 10'd2, 10'd1, GAIN_RST, OFFSET_RST);
        send_sample(16'sd100, rand_sample(), 1'b1);     // ping held
        send_sample(16'sd200, rand_sample(), 1'b0);     // pong armed but busy
        send_sample(16'sd300, rand_sample(), 1'b0);     // ping emitted, still busy
        send_sample(16'sd100, rand_sample(), 1'b0);     // pong held
        send_sample(16'sd0, rand_sample(), 1'b1);       // new event drops it
        send_sample(16'sd150, rand_sample(), 1'b0);     // ping held, due two later
        send_sample(16'sd0, rand_sample(), 1'b0);
        send_sample(16'sd0, rand_sample(), 1'b1);       // due on an event start: lost
        send_sample(16'sd500, rand_sample(), 1'b1);     // trigger on sample 0 of an event
    endtask

    // one full 1024-sample window: long hold, longest dead time, capture lost at close
    task automatic test_event_window();
        wait_for_captures();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_all(16'd0, 10'd1022, 10'd1023, GAIN_RST, OFFSET_RST);
        // ping at 0 emitted on index 1022; pong on the last index is held and then lost
        for (int k = 0; k <= LAST_INDEX; k++) begin
            send_sample(SB'(rand_between(0, 32767)), rand_sample(), k == 0);
        end
        // window closed: triggers ignored until the next event start
        repeat (2) send_sample(16'sd32767, rand_sample(), 1'b0);
    endtask

    // receiver holds off for a long stretch while short events keep producing captures
    task automatic test_backpressure();
        wait_for_captures();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_all(16'h8000, 10'd0, 10'd1, 16'($urandom), 16'($urandom));
        hold_off_request = HOLD_OFF_LEN;
        repeat (30) begin
            send_sample(rand_sample(), rand_sample(), 1'b1);
            repeat (2) send_sample(rand_sample(), rand_sample(), 1'b0);
        end
        // sender pauses until the backlog is gone
        wait_for_captures();
        recv_idle_pct = 59;
        repeat (30) begin
            send_sample(rand_sample(), rand_sample(), 1'b1);
            repeat (2) send_sample(rand_sample(), rand_sample(), 1'b0);
        end
    endtask

    // random phases: new settings each phase, mostly well-formed events with pulses
    task automatic test_random();
        int n_phases;
        int sent;
        int len;
        int pick;
        logic [15:0] level;
        logic [9:0]  hold;
        logic [9:0]  dead;
        logic [15:0] gain;
        logic [15:0] offset;
        n_phases = RANDOM_ITEMS / PHASE_ITEMS;
        for (int p = 0; p < n_phases; p++) begin
            wait_for_captures();
            // receiver idles most first, then the sides swap, then no idling at all
            case (p * 3 / n_phases)
                0:       begin send_idle_pct = 28; recv_idle_pct = 59; end
                1:       begin send_idle_pct = 59; recv_idle_pct = 28; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase

            pick = $urandom_range(99);
            if (pick < 5) begin
                level = 16'h8000;
            end else if (pick < 10) begin
                level = 16'h7fff;
            end else begin
                level = 16'(rand_between(-3000, 3000));
            end
            pick = $urandom_range(99);
            hold = (pick < 15) ? 10'd0 : (pick < 85) ? 10'(rand_between(1, 20))
                                                     : 10'(rand_between(21, 60));
            pick = $urandom_range(99);
            dead = (pick < 10) ? 10'd0 : (pick < 90) ? 10'(rand_between(1, 30))
                                                     : 10'(rand_between(31, 100));
            pick = $urandom_range(99);
            gain = (pick < 5) ? 16'd0 : (pick < 10) ? 16'hffff : 16'($urandom);
            pick = $urandom_range(99);
            offset = (pick < 5) ? 16'd0 : (pick < 10) ? 16'hffff : 16'($urandom);
            write_all(level, hold, dead, gain, offset);

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if (sent == 0 || $urandom_range(99) < 85) begin
                    // event: start marker then baseline with random pulses over the level
                    len = rand_between(3, 60);
                    for (int k = 0; k < len; k++) begin
                        send_sample(pick_fast($urandom_range(99) < 20), rand_sample(), k == 0);
                    end
                end else begin
                    // noise: anything at all, stray event starts included
                    len = rand_between(1, 8);
                    for (int k = 0; k < len; k++) begin
                        send_sample(rand_sample(), rand_sample(), $urandom_range(99) < 10);
                    end
                end
                sent += len;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_idx             = CFG_TRIGGER_LEVEL;
        i_cfg_data            = '0;
        sample_if.valid       = 1'b0;
        sample_if.fast_sample = '0;
        sample_if.slow_sample = '0;
        sample_if.event_start = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_values();
        test_extremes();
        test_busy_and_event_start();
        test_event_window();
        test_backpressure();
        test_random();

        wait_for_captures();
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/pptcc_pkg.sv
rtl/core/pptcc_in_if.sv
rtl/core/pptcc_out_if.sv
rtl/core/pptcc_ctrl.sv
rtl/core/pptcc_scale.sv
rtl/core/ping_pong_trigger_charge_capture.sv
dv/ping_pong_trigger_charge_capture_tb.sv
